>>> sv/atpp_pkg.sv
// Shared types, character codes and helpers for the AT parameter parser.
package atpp_pkg;

  // Highest parameter number the format can describe
  localparam int MAX_PARAMS = 16;
  // Default depth of the result queue between parser and output
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic CFG_PARAM_KINDS = 1'b0;
  localparam logic CFG_PARAM_COUNT = 1'b1;

  // Character codes
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;

  // Request types on the input channel
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Largest integer value; accumulator saturates here
  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    PK_SKIP = 2'd0,
    PK_INT  = 2'd1,
    PK_STR  = 2'd2,
    PK_HEX  = 2'd3
  } pkind_t;

  typedef enum logic [2:0] {
    OK_STR_BYTE = 3'd0,
    OK_HEX_BYTE = 3'd1,
    OK_COMPLETE = 3'd2,
    OK_DONE     = 3'd3,
    OK_ERROR    = 3'd4
  } out_kind_t;

  // One result item
  typedef struct packed {
    out_kind_t   kind;
    logic [4:0]  idx;
    logic [7:0]  data;
    logic [30:0] ival;
    logic [4:0]  tot;
  } atpp_res_t;

  // All results of one input item: one or two
  typedef struct packed {
    logic      two;
    atpp_res_t r0;
    atpp_res_t r1;
  } atpp_entry_t;

  function automatic atpp_res_t mk_res(out_kind_t kind, logic [4:0] idx,
                                       logic [7:0] data, logic [30:0] ival,
                                       logic [4:0] tot);
    atpp_res_t r;
    r.kind = kind;
    r.idx  = idx;
    r.data = data;
    r.ival = ival;
    r.tot  = tot;
    return r;
  endfunction

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (c inside {[CH_LC_A:CH_LC_F]}) begin
      r = {1'b1, 4'(c - CH_LC_A + 8'd10)};
    end else if (c inside {[CH_UC_A:CH_UC_F]}) begin
      r = {1'b1, 4'(c - CH_UC_A + 8'd10)};
    end
    return r;
  endfunction

endpackage

>>> sv/atpp_front.sv
// Parser front end: configuration registers, character classification, result building.
module atpp_front import atpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_ch,
  input  logic        q_full,
  output logic        push,
  output atpp_entry_t push_entry
);

  logic [31:0] kinds_r;
  logic [4:0]  count_r;

  logic        in_quote_r, in_quote_nxt;
  logic        esc_r, esc_nxt;
  logic [5:0]  pn_r, pn_nxt;
  logic        start_r, start_nxt;
  logic        qs_r, qs_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        held_v_r, held_v_nxt;
  logic [3:0]  hex_hi_r, hex_hi_nxt;
  logic        phase_r, phase_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic        halted_r, halted_nxt;

  logic        accept;
  logic [4:0]  eff;
  logic        in_range;
  logic [3:0]  pidx;
  pkind_t      kind;
  logic [34:0] acc_wide;
  logic [4:0]  nib;
  logic        is_digit;

  atpp_res_t   res_a [2];
  logic [1:0]  n;
  logic        content_en;
  logic        end_ok;
  logic [4:0]  end_tot;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Effective parameter count and current parameter's kind
  assign eff      = (count_r > 5'(MAX_PARAMS)) ? 5'(MAX_PARAMS) : count_r;
  assign in_range = (pn_r <= {1'b0, eff});
  assign pidx     = 4'(pn_r - 6'd1);
  assign kind     = (pn_r == 6'd0 || pn_r > 6'd16) ? PK_SKIP
                                                   : pkind_t'(kinds_r[{pidx, 1'b0} +: 2]);

  // Decimal step: acc*10 + digit, checked for saturation
  assign is_digit = in_ch inside {[CH_ZERO:CH_NINE]};
  assign acc_wide = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + 35'(in_ch - CH_ZERO);
  assign nib      = hex_nibble(in_ch);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kinds_r <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PARAM_KINDS: kinds_r <= cfg_wdata;
        CFG_PARAM_COUNT: count_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Parser next state and results
  always_comb begin
    in_quote_nxt = in_quote_r;
    esc_nxt      = esc_r;
    pn_nxt       = pn_r;
    start_nxt    = start_r;
    qs_nxt       = qs_r;
    held_nxt     = held_r;
    held_v_nxt   = held_v_r;
    hex_hi_nxt   = hex_hi_r;
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    halted_nxt   = halted_r;
    res_a[0]     = '0;
    res_a[1]     = '0;
    n            = 2'd0;
    content_en   = 1'b0;
    end_ok       = 1'b1;
    end_tot      = eff;

    if (accept) begin
      if (in_req_type == REQ_END) begin
        if (!halted_r) begin
          if (in_range) begin
            end_tot = pn_r[4:0];
            if (in_quote_r || esc_r || (kind == PK_INT && start_r) ||
                (kind == PK_HEX && phase_r)) begin
              res_a[n[0]] = mk_res(OK_ERROR, pn_r[4:0], 8'd0, 31'd0, 5'd0);
              n = n + 2'd1;
              end_ok = 1'b0;
            end else begin
              res_a[n[0]] = mk_res(OK_COMPLETE, pn_r[4:0], 8'd0,
                                   (kind == PK_INT) ? acc_r : 31'd0, 5'd0);
              n = n + 2'd1;
            end
          end
          if (end_ok) begin
            res_a[n[0]] = mk_res(OK_DONE, 5'd0, 8'd0, 31'd0, end_tot);
            n = n + 2'd1;
          end
        end
        // Ready for a new text
        halted_nxt   = 1'b0;
        pn_nxt       = 6'd1;
        in_quote_nxt = 1'b0;
        esc_nxt      = 1'b0;
        start_nxt    = 1'b1;
        qs_nxt       = 1'b0;
        held_nxt     = 8'd0;
        held_v_nxt   = 1'b0;
        hex_hi_nxt   = 4'd0;
        phase_nxt    = 1'b0;
        acc_nxt      = 31'd0;
      end else if (!halted_r && in_range) begin
        // Quote and escape tracking
        if (esc_r) begin
          esc_nxt    = 1'b0;
          content_en = 1'b1;
        end else if (in_ch == CH_BSLASH) begin
          esc_nxt    = 1'b1;
          content_en = 1'b1;
        end else if (in_quote_r) begin
          if (in_ch == CH_QUOTE) begin
            in_quote_nxt = 1'b0;
          end
          content_en = 1'b1;
        end else if (in_ch == CH_QUOTE) begin
          in_quote_nxt = 1'b1;
          content_en   = 1'b1;
        end else if (in_ch == CH_COMMA) begin
          // Parameter boundary
          if ((kind == PK_INT && start_r) || (kind == PK_HEX && phase_r)) begin
            res_a[n[0]] = mk_res(OK_ERROR, pn_r[4:0], 8'd0, 31'd0, 5'd0);
            n = n + 2'd1;
            halted_nxt = 1'b1;
          end else begin
            res_a[n[0]] = mk_res(OK_COMPLETE, pn_r[4:0], 8'd0,
                                 (kind == PK_INT) ? acc_r : 31'd0, 5'd0);
            n = n + 2'd1;
            pn_nxt       = pn_r + 6'd1;
            in_quote_nxt = 1'b0;
            esc_nxt      = 1'b0;
            start_nxt    = 1'b1;
            qs_nxt       = 1'b0;
            held_nxt     = 8'd0;
            held_v_nxt   = 1'b0;
            hex_hi_nxt   = 4'd0;
            phase_nxt    = 1'b0;
            acc_nxt      = 31'd0;
          end
        end else begin
          content_en = 1'b1;
        end

        // Content handling by parameter kind
        if (content_en) begin
          start_nxt = 1'b0;
          case (kind)
            PK_INT: begin
              if (!is_digit) begin
                res_a[n[0]] = mk_res(OK_ERROR, pn_r[4:0], 8'd0, 31'd0, 5'd0);
                n = n + 2'd1;
                halted_nxt = 1'b1;
              end else if (|acc_wide[34:31]) begin
                acc_nxt = INT_MAX31;
              end else begin
                acc_nxt = acc_wide[30:0];
              end
            end
            PK_HEX: begin
              if (!nib[4]) begin
                res_a[n[0]] = mk_res(OK_ERROR, pn_r[4:0], 8'd0, 31'd0, 5'd0);
                n = n + 2'd1;
                halted_nxt = 1'b1;
              end else if (phase_r) begin
                res_a[n[0]] = mk_res(OK_HEX_BYTE, pn_r[4:0], {hex_hi_r, nib[3:0]},
                                     31'd0, 5'd0);
                n = n + 2'd1;
                phase_nxt = 1'b0;
              end else begin
                hex_hi_nxt = nib[3:0];
                phase_nxt  = 1'b1;
              end
            end
            PK_STR: begin
              if (start_r && in_ch == CH_QUOTE) begin
                qs_nxt = 1'b1;
              end else if (qs_r) begin
                // Hold back one char so the closing quote can be dropped
                if (held_v_r) begin
                  res_a[n[0]] = mk_res(OK_STR_BYTE, pn_r[4:0], held_r, 31'd0, 5'd0);
                  n = n + 2'd1;
                end
                held_nxt   = in_ch;
                held_v_nxt = 1'b1;
              end else begin
                res_a[n[0]] = mk_res(OK_STR_BYTE, pn_r[4:0], in_ch, 31'd0, 5'd0);
                n = n + 2'd1;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  assign push            = accept && (n != 2'd0);
  assign push_entry.two  = n[1];
  assign push_entry.r0   = res_a[0];
  assign push_entry.r1   = res_a[1];

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quote_r <= 1'b0;
      esc_r      <= 1'b0;
      pn_r       <= 6'd1;
      start_r    <= 1'b1;
      qs_r       <= 1'b0;
      held_r     <= 8'd0;
      held_v_r   <= 1'b0;
      hex_hi_r   <= 4'd0;
      phase_r    <= 1'b0;
      acc_r      <= 31'd0;
      halted_r   <= 1'b0;
    end else begin
      in_quote_r <= in_quote_nxt;
      esc_r      <= esc_nxt;
      pn_r       <= pn_nxt;
      start_r    <= start_nxt;
      qs_r       <= qs_nxt;
      held_r     <= held_nxt;
      held_v_r   <= held_v_nxt;
      hex_hi_r   <= hex_hi_nxt;
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

>>> sv/atpp_queue.sv
// Result queue between parser front end and output sequencer.
module atpp_queue import atpp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  atpp_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        empty,
  output atpp_entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  atpp_entry_t    mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> sv/atpp_back.sv
// Output sequencer: plays out the one or two results of each queued entry.
module atpp_back import atpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  atpp_entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [4:0]  out_param_index,
  output logic [7:0]  out_data_byte,
  output logic [30:0] out_int_value,
  output logic [4:0]  out_total,
  output logic        out_last
);

  logic      sub_r, sub_nxt;
  logic      fire;
  atpp_res_t sel;

  assign out_valid = !q_empty;
  assign sel       = sub_r ? head.r1 : head.r0;
  assign out_last  = !head.two || sub_r;
  assign fire      = out_valid && out_ready;
  assign pop       = fire && out_last;

  assign out_kind        = sel.kind;
  assign out_param_index = sel.idx;
  assign out_data_byte   = sel.data;
  assign out_int_value   = sel.ival;
  assign out_total       = sel.tot;

  // Second-result select
  always_comb begin
    sub_nxt = sub_r;
    if (fire) begin
      sub_nxt = !out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

>>> sv/at_param_parser.sv
// Top level of the AT parameter parser: front end, result queue, output sequencer.
//
// Usage:
//   Configure param_kinds (cfg_index 0) and param_count (cfg_index 1) through
//   the write port while the block is idle. Then send the parameter text one
//   character per transfer on the in_ channel (in_req_type 0), closed by an
//   end-of-text transfer (in_req_type 1).
//   Each transfer yields zero, one or two results on the out_ channel; the
//   final result of a transfer carries out_last.
// Flow:
//   One character is taken per cycle while in_ready is high. Results pass
//   through the result queue to the out_ channel. An end of text that
//   completes a parameter and reports done yields two results.
// Stalls:
//   While out_ready is low, results wait in a queue of QUEUE_DEPTH_P entries
//   (one entry per transfer that yields results); in_ready drops only when full.
// Reset:
//   Synchronous, active low. Clears both configuration registers, the parser
//   state and the queue. After an error the parser ignores text until the
//   next end of text, which gives no result.
module at_param_parser import atpp_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [4:0]  out_param_index,
  output logic [7:0]  out_data_byte,
  output logic [30:0] out_int_value,
  output logic [4:0]  out_total,
  output logic        out_last
);

  logic        q_full, q_empty, q_push, q_pop;
  atpp_entry_t q_wentry, q_head;

  atpp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req_type(in_req_type),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_wentry)
  );

  atpp_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_wentry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  atpp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_param_index(out_param_index),
    .out_data_byte  (out_data_byte),
    .out_int_value  (out_int_value),
    .out_total      (out_total),
    .out_last       (out_last)
  );

  // Done always closes the results of its transfer
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == OK_DONE |-> out_last)
    else $error("done result without last");

  // An error always closes the results of its transfer
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == OK_ERROR |-> out_last)
    else $error("error result without last");

  // Reported count never exceeds the parameter limit
  a_done_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == OK_DONE |-> out_total <= 5'(MAX_PARAMS))
    else $error("done total out of range");

  // The front end never pushes into a full queue
  a_push_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into full queue");

endmodule
